[sv/bdsl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bdsl_pkg;

	localparam int BTN_FIELD_W = 5;
	localparam int QUERY_W     = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int HELD_W      = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_ENABLE     = 2'd2
	} cfg_reg_t;

	localparam logic [CFG_DATA_W-1:0]  DEBOUNCE_RST   = 16'd30;
	localparam logic [CFG_DATA_W-1:0]  LONG_PRESS_RST = 16'd1000;
	localparam logic [BTN_FIELD_W-1:0] ENABLE_RST     = 5'h1F;

	typedef struct packed {
		logic [BTN_FIELD_W-1:0] raw_pressed;
		logic [BTN_FIELD_W-1:0] consume_short;
		logic [BTN_FIELD_W-1:0] consume_long;
		logic [QUERY_W-1:0]     query_button;
	} in_item_t;

	typedef struct packed {
		logic [BTN_FIELD_W-1:0] down_mask;
		logic [BTN_FIELD_W-1:0] short_pending;
		logic [BTN_FIELD_W-1:0] long_pending;
		logic [HELD_W-1:0]      held_time;
	} out_item_t;

	typedef struct packed {
		logic down;
		logic short_p;
		logic long_p;
	} lane_stat_t;

endpackage

`default_nettype wire

[sv/bdsl_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdsl_lane
	import bdsl_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tick,
	input  wire logic                  take,
	input  wire logic                  raw,
	input  wire logic                  consume_short,
	input  wire logic                  consume_long,
	input  wire logic [CFG_DATA_W-1:0] debounce_ticks,
	input  wire logic [CFG_DATA_W-1:0] long_press_ticks,
	output lane_stat_t                 stat,
	output logic      [TIMER_BITS-1:0] hold
);

	localparam int CW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

	logic                  raw_seen_q, stable_q, long_done_q, short_q, long_q;
	logic [TIMER_BITS-1:0] since_q, hold_q;

	logic                  raw_n, stable_n, long_done_n, short_n, long_n;
	logic [TIMER_BITS-1:0] since_n, hold_n;

	always_comb begin
		raw_n       = raw_seen_q;
		stable_n    = stable_q;
		long_done_n = long_done_q;
		short_n     = short_q;
		long_n      = long_q;
		since_n     = (since_q == '1) ? since_q : since_q + TIMER_BITS'(1);
		hold_n      = hold_q;
		if (stable_q && hold_q != '1) begin
			hold_n = hold_q + TIMER_BITS'(1);
		end
		if (raw != raw_seen_q) begin
			raw_n   = raw;
			since_n = '0;
		end
		if (CW'(since_n) >= CW'(debounce_ticks)) begin
			if (raw_n != stable_q) begin
				stable_n = raw_n;
				if (raw_n) begin
					hold_n      = '0;
					long_done_n = 1'b0;
				end else if (!long_done_q && CW'(hold_n) < CW'(long_press_ticks)) begin
					short_n = 1'b1;
				end
			end
			if (stable_n && !long_done_n && CW'(hold_n) >= CW'(long_press_ticks)) begin
				long_n      = 1'b1;
				long_done_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q  <= 1'b0;
			stable_q    <= 1'b0;
			long_done_q <= 1'b0;
			short_q     <= 1'b0;
			long_q      <= 1'b0;
			since_q     <= '0;
			hold_q      <= '0;
		end else begin
			if (tick) begin
				raw_seen_q  <= raw_n;
				stable_q    <= stable_n;
				long_done_q <= long_done_n;
				since_q     <= since_n;
				hold_q      <= hold_n;
			end
			if (take) begin
				short_q <= stat.short_p & ~consume_short;
				long_q  <= stat.long_p & ~consume_long;
			end
		end
	end

	assign stat.down    = tick ? stable_n : stable_q;
	assign stat.short_p = tick ? short_n : short_q;
	assign stat.long_p  = tick ? long_n : long_q;
	assign hold         = tick ? hold_n : hold_q;

endmodule

`default_nettype wire

[sv/bdsl_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module bdsl_merge
	import bdsl_pkg::*;
#(
	parameter int NUM_BUTTONS = 5,
	parameter int TIMER_BITS  = 16
) (
	input  lane_stat_t                   stat [NUM_BUTTONS],
	input  wire logic [TIMER_BITS-1:0]   hold [NUM_BUTTONS],
	input  wire logic [NUM_BUTTONS-1:0]  en,
	input  wire logic [QUERY_W-1:0]      query,
	output out_item_t                    item
);

	localparam int NV = (NUM_BUTTONS < BTN_FIELD_W) ? NUM_BUTTONS : BTN_FIELD_W;
	localparam int CW = (TIMER_BITS > HELD_W) ? TIMER_BITS : HELD_W;

	logic [TIMER_BITS-1:0] sel;
	logic [CW-1:0]         sel_w;

	always_comb begin
		sel                = '0;
		item.down_mask     = '0;
		item.short_pending = '0;
		item.long_pending  = '0;
		for (int b = 0; b < NV; b++) begin
			item.down_mask[b]     = en[b] & stat[b].down;
			item.short_pending[b] = stat[b].short_p;
			item.long_pending[b]  = stat[b].long_p;
		end
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			if (int'(query) == b && en[b] && stat[b].down) begin
				sel = hold[b];
			end
		end
		sel_w          = CW'(sel);
		item.held_time = (sel_w > CW'({HELD_W{1'b1}})) ? {HELD_W{1'b1}} : sel_w[HELD_W-1:0];
	end

endmodule

`default_nettype wire

[sv/button_debounce_short_long_press_core.sv]
// Debounced button bank with short and long press detection.
// Input channel (in_valid / in_stall / in_item): one request per millisecond
// tick with the raw pressed levels, the short and long consume masks and the
// index of the button whose hold time is wanted.
// Output channel (out_valid / out_stall / out_item): one result per request
// with the debounced down mask, the pending flags before consuming and the
// held time of the queried button.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// debounce ticks, 1 long press ticks, 2 enable mask; other indexes are
// dropped. cfg_ready is always high; write only while the block is idle.
// One lane per button updates its counters in the accept cycle if enabled;
// the result is registered in out_q, or in skid_q if out_q is full and
// not popped. Throughput is one request per cycle while in_stall is low.
// A two-entry output buffer holds results while out_stall is high; the
// block takes one more request and then raises in_stall until a slot frees.
// Reset: all buttons released, flags and counters clear, registers at
// 30 / 1000 / all enabled, output buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_short_long_press_core
	import bdsl_pkg::*;
#(
	parameter int NUM_BUTTONS = 5,
	parameter int TIMER_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  in_item_t                   in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NV = (NUM_BUTTONS < BTN_FIELD_W) ? NUM_BUTTONS : BTN_FIELD_W;

	logic [CFG_DATA_W-1:0]  debounce_q, long_press_q;
	logic [BTN_FIELD_W-1:0] enable_q;
	logic [NUM_BUTTONS-1:0] en;
	logic                   acc, pop;

	lane_stat_t            stat [NUM_BUTTONS];
	logic [TIMER_BITS-1:0] hold [NUM_BUTTONS];
	out_item_t             result;

	out_item_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;

	assign cfg_ready = 1'b1;
	assign acc       = in_valid && !in_stall;
	assign pop       = out_valid_q && !out_stall;
	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			enable_q     <= ENABLE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   debounce_q   <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_ENABLE:     enable_q     <= cfg_data[BTN_FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		en = '0;
		for (int b = 0; b < NV; b++) begin
			en[b] = enable_q[b];
		end
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		logic raw_b, cs_b, cl_b;
		if (b < BTN_FIELD_W) begin : g_wired
			assign raw_b = in_item.raw_pressed[b];
			assign cs_b  = in_item.consume_short[b];
			assign cl_b  = in_item.consume_long[b];
		end else begin : g_unwired
			assign raw_b = 1'b0;
			assign cs_b  = 1'b0;
			assign cl_b  = 1'b0;
		end

		bdsl_lane #(
			.TIMER_BITS(TIMER_BITS)
		) u_lane (
			.clk             (clk),
			.arst_n          (arst_n),
			.tick            (acc && en[b]),
			.take            (acc),
			.raw             (raw_b),
			.consume_short   (cs_b),
			.consume_long    (cl_b),
			.debounce_ticks  (debounce_q),
			.long_press_ticks(long_press_q),
			.stat            (stat[b]),
			.hold            (hold[b])
		);
	end

	bdsl_merge #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.TIMER_BITS (TIMER_BITS)
	) u_merge (
		.stat (stat),
		.hold (hold),
		.en   (en),
		.query(in_item.query_button),
		.item (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (acc) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (acc) begin
			if (!out_valid_q || pop) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

endmodule

`default_nettype wire
